/* sv/oxvt_pkg.sv */
// Package for the oxygen sensor voltage tracker.
// Holds the field widths, limits, register indexes, mixture event codes and a voltage clamp.
// No dependencies.
package oxvt_pkg;

    localparam int VOLT_W    = 10;
    localparam int WORD_W    = 16;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [VOLT_W-1:0]  VOLT_MAX    = 10'd1023;
    localparam logic [WORD_W-1:0]  INHIBIT_CAP = 16'd52428;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHORT_THRESHOLD  = 2'd0,
        REG_INHIBIT_DELAY    = 2'd1,
        REG_TEST_BED_ENABLE  = 2'd2,
        REG_TEST_BED_VOLTAGE = 2'd3
    } cfg_index_t;

    // Mixture event codes
    typedef enum logic [1:0] {
        MIX_NONE         = 2'd0,
        MIX_LEAN_TO_RICH = 2'd1,
        MIX_RICH_TO_LEAN = 2'd2,
        MIX_FREEZE_LEAN  = 2'd3
    } mixture_t;

    // Clamp a 16-bit voltage to the 10-bit range
    function automatic logic [VOLT_W-1:0] clamp_volt(input logic [WORD_W-1:0] v);
        logic [VOLT_W-1:0] r;
        if (v > WORD_W'(VOLT_MAX))
            r = VOLT_MAX;
        else
            r = v[VOLT_W-1:0];
        return r;
    endfunction

endpackage

/* sv/oxygen_sensor_voltage_tracker.sv */
// Top level of the oxygen sensor voltage tracker.
// Input register, one pass of tracking logic, result register. Uses oxvt_pkg.
//
// One tick is accepted per cycle while in_ready is high and its result is
// written to the result register when that register is free; throughput is one
// tick per clock unless the output stalls. The tracker state (extrema, inhibit
// counter, mixture flag) is updated from the input register together with the
// result register. Ready goes low only when both the input and result registers
// hold items and the result is not taken. Configuration writes take effect at
// the next clock edge and should be made only while no tick is in flight.
module oxygen_sensor_voltage_tracker
    import oxvt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,

    // input channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [WORD_W-1:0]    raw_sample,
    input  logic [WORD_W-1:0]    filtered_volt,
    input  logic                 diag_inhibit,
    input  logic                 engine_running,
    input  logic                 first_computed,
    input  logic                 cycle_sync,
    input  logic                 injection_cut,
    input  logic [1:0]           mixture_event,

    // output channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [VOLT_W-1:0]    raw_volt,
    output logic [VOLT_W-1:0]    sensor_volt,
    output logic                 short_fault,
    output logic [VOLT_W-1:0]    cycle_max,
    output logic [VOLT_W-1:0]    cycle_min,
    output logic [WORD_W-1:0]    inhibit_left,
    output logic                 mixture_rich,
    output logic [COUNT_W-1:0]   transition_count
);

    // configuration registers
    logic [VOLT_W-1:0] thr_reg;
    logic [WORD_W-1:0] delay_reg;
    logic              tb_en_reg;
    logic [WORD_W-1:0] tb_volt_reg;

    // input stage
    logic              s1_valid_reg;
    logic [WORD_W-1:0] s1_raw_reg;
    logic [WORD_W-1:0] s1_filt_reg;
    logic              s1_diag_reg;
    logic              s1_run_reg;
    logic              s1_first_reg;
    logic              s1_sync_reg;
    logic              s1_cut_reg;
    mixture_t          s1_mix_reg;

    // tracker state
    logic [VOLT_W-1:0]  held_reg,    held_next;
    logic [VOLT_W-1:0]  rmax_reg,    rmax_next;
    logic [VOLT_W-1:0]  rmin_reg,    rmin_next;
    logic [VOLT_W-1:0]  lmax_reg,    lmax_next;
    logic [VOLT_W-1:0]  lmin_reg,    lmin_next;
    logic [WORD_W-1:0]  inhibit_reg, inhibit_next;
    logic               rich_reg,    rich_next;
    logic [COUNT_W-1:0] edge_reg,    edge_next;

    // result stage
    logic               out_valid_reg;
    logic [VOLT_W-1:0]  raw_volt_reg, raw_volt_next;
    logic               fault_reg,    fault_next;

    logic s1_adv;
    logic out_free;

    // handshake: result register frees when empty or taken
    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= VOLT_MAX;
            delay_reg   <= '0;
            tb_en_reg   <= 1'b0;
            tb_volt_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SHORT_THRESHOLD:  thr_reg     <= cfg_data[VOLT_W-1:0];
                REG_INHIBIT_DELAY:    delay_reg   <= cfg_data;
                REG_TEST_BED_ENABLE:  tb_en_reg   <= cfg_data[0];
                REG_TEST_BED_VOLTAGE: tb_volt_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_raw_reg   <= raw_sample;
            s1_filt_reg  <= filtered_volt;
            s1_diag_reg  <= diag_inhibit;
            s1_run_reg   <= engine_running;
            s1_first_reg <= first_computed;
            s1_sync_reg  <= cycle_sync;
            s1_cut_reg   <= injection_cut;
            s1_mix_reg   <= mixture_t'(mixture_event);
        end
    end

    // one tick of tracking
    always_comb
    begin
        logic [VOLT_W-1:0] sel_volt;
        logic              is_short;

        held_next = held_reg;
        rmax_next = rmax_reg;
        rmin_next = rmin_reg;
        lmax_next = lmax_reg;
        lmin_next = lmin_reg;
        rich_next = rich_reg;
        edge_next = edge_reg;

        // divide by four and clamp
        if (s1_raw_reg[WORD_W-1:VOLT_W+2] != '0)
            raw_volt_next = VOLT_MAX;
        else
            raw_volt_next = s1_raw_reg[VOLT_W+1:2];

        is_short   = (raw_volt_next >= thr_reg);
        fault_next = is_short && !s1_diag_reg;
        sel_volt   = clamp_volt(tb_en_reg ? tb_volt_reg : s1_filt_reg);

        // voltage select when not shorted; extrema gated by the counter before update, first and running
        if (!is_short)
        begin
            held_next = sel_volt;
            if (inhibit_reg == '0 && s1_first_reg && s1_run_reg)
            begin
                if (sel_volt > rmax_reg)
                    rmax_next = sel_volt;
                if (sel_volt < rmin_reg)
                    rmin_next = sel_volt;
                if (s1_sync_reg)
                begin
                    lmax_next = rmax_next;
                    lmin_next = rmin_next;
                end
            end
        end

        // inhibit counter
        priority if (s1_cut_reg)
            inhibit_next = (delay_reg > INHIBIT_CAP) ? INHIBIT_CAP : delay_reg;
        else if (inhibit_reg > INHIBIT_CAP)
            inhibit_next = INHIBIT_CAP;
        else if (inhibit_reg != '0)
            inhibit_next = inhibit_reg - 1'b1;
        else
            inhibit_next = inhibit_reg;

        // mixture events
        unique case (s1_mix_reg)
            MIX_LEAN_TO_RICH, MIX_RICH_TO_LEAN:
            begin
                rich_next = (s1_mix_reg == MIX_LEAN_TO_RICH);
                if (edge_reg < COUNT_MAX)
                    edge_next = edge_reg + 1'b1;
            end
            MIX_FREEZE_LEAN: rich_next = 1'b0;
            MIX_NONE:        ;
            default:         ;
        endcase
    end

    // tracker state, advanced once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            rmax_reg    <= '0;
            rmin_reg    <= VOLT_MAX;
            lmax_reg    <= '0;
            lmin_reg    <= '0;
            inhibit_reg <= '0;
            rich_reg    <= 1'b0;
            edge_reg    <= '0;
        end
        else if (s1_adv)
        begin
            held_reg    <= held_next;
            rmax_reg    <= rmax_next;
            rmin_reg    <= rmin_next;
            lmax_reg    <= lmax_next;
            lmin_reg    <= lmin_next;
            inhibit_reg <= inhibit_next;
            rich_reg    <= rich_next;
            edge_reg    <= edge_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            raw_volt_reg <= raw_volt_next;
            fault_reg    <= fault_next;
        end
    end

    // outputs; state after the tick is the result payload
    assign out_valid        = out_valid_reg;
    assign raw_volt         = raw_volt_reg;
    assign short_fault      = fault_reg;
    assign sensor_volt      = held_reg;
    assign cycle_max        = lmax_reg;
    assign cycle_min        = lmin_reg;
    assign inhibit_left     = inhibit_reg;
    assign mixture_rich     = rich_reg;
    assign transition_count = edge_reg;

    // checks
    a_inhibit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        inhibit_reg <= INHIBIT_CAP)
        else $error("inhibit counter above cap");

    a_fault_thr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fault_reg |-> raw_volt_reg >= thr_reg)
        else $error("short fault without raw voltage at threshold");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && !s1_cut_reg && inhibit_reg != '0 |=>
        inhibit_reg == $past(inhibit_reg) - 1'b1)
        else $error("inhibit counter did not count down");

    a_edge_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(edge_reg) && $stable(held_reg))
        else $error("tracker state changed without a tick");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

endmodule
